/* rtl/core/plb_pkg.sv */
// Shared request codes, status codes and the shift command type for the list buffer.
package plb_pkg;

    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // request codes
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [2:0] REQ_POP_BACK   = 3'd2;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [2:0] REQ_INSERT     = 3'd4;
    localparam logic [2:0] REQ_ERASE      = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic       shift_up;    // open a gap at the target index
        logic       shift_down;  // close the gap at the target index
        logic [1:0] status;
    } plb_cmd_t;

endpackage

/* rtl/core/positional_list_buffer.sv */
// Top level of the positional list buffer: decoder, chain of slot cells, result register.
//
// Fixed-capacity ordered list, kept packed from slot zero.
// Request channel (in_valid/in_ready): req_type, position, data_value.
//   Codes: push back, push front, pop back, pop front, insert at position,
//   erase at position; codes six and seven are no-ops that report ok.
// Result channel (out_valid/out_ready): status, count, removed_value, one
//   result transaction per request transaction, in order.
// A result is valid the cycle after its request is taken.
// Throughput: one request per cycle while in_ready is high. Every cell compares
//   its own index with the target and loads its left neighbor, its right
//   neighbor or the new value, so the whole list shifts at once.
// The result register holds one result; in_ready stays high while it is
//   empty or being drained the same cycle, so a stalled receiver stops new
//   requests after one result is parked and nothing is lost.
// Reset (rst_n low, asynchronous) empties the list and drops any pending
//   result. Slot contents are not cleared; slots at or above the count are
//   never read back.
// count reports the low five bits of the fill count after the request.
module positional_list_buffer #(
    parameter int unsigned CAPACITY   = plb_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = plb_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [4:0]  position,
    input  logic [31:0] data_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  count,
    output logic [31:0] removed_value
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);

    // control state
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] fill_count_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // result payload
    logic [1:0]            status_reg;
    logic [4:0]            result_count_reg;
    logic [DATA_WIDTH-1:0] removed_reg;
    logic [DATA_WIDTH-1:0] removed_next;

    logic                  in_fire;
    plb_pkg::plb_cmd_t     dec_cmd;
    plb_pkg::plb_cmd_t     cell_cmd;
    logic [IW-1:0]         target;
    logic [DATA_WIDTH-1:0] ins_value;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign ins_value = DATA_WIDTH'(data_value);

    plb_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .IW       (IW)
    ) u_ctrl (
        .req_type   (req_type),
        .position   (position),
        .fill_count (fill_count_reg),
        .cmd        (dec_cmd),
        .target     (target)
    );

    // cells only move on an accepted transaction
    always_comb
    begin
        cell_cmd            = dec_cmd;
        cell_cmd.shift_up   = dec_cmd.shift_up && in_fire;
        cell_cmd.shift_down = dec_cmd.shift_down && in_fire;
    end

    // chain of slots: each feeds its neighbors; the ends tie off to values
    // that only land in slots at or above the count
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = ins_value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        plb_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .target     (target),
            .ins_value  (ins_value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // removed value: only the target cell drives a nonzero tap
    always_comb
    begin
        removed_next = '0;
        if (dec_cmd.shift_down)
        begin
            for (int k = 0; k < CAPACITY; k++)
            begin
                removed_next = removed_next | cell_tap[k];
            end
        end
    end

    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (cell_cmd.shift_up)
            fill_count_next = fill_count_reg + 1'b1;
        else if (cell_cmd.shift_down)
            fill_count_next = fill_count_reg - 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg       <= dec_cmd.status;
            result_count_reg <= 5'(fill_count_next);
            removed_reg      <= removed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign count         = result_count_reg;
    assign removed_value = 32'(removed_reg);

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_reject_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (dec_cmd.status != plb_pkg::ST_OK)) |=> $stable(fill_count_reg))
        else $error("rejected request changed the fill count");

    a_grow_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && dec_cmd.shift_up) |=> (fill_count_reg == $past(fill_count_reg) + 1'b1))
        else $error("insert did not grow the list by one");

    a_result_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_count_reg == 5'(fill_count_reg)))
        else $error("reported count differs from fill count");
`endif

endmodule

/* rtl/core/plb_ctrl.sv */
// Request decoder: checks a request against the fill count and picks the shift.
module plb_ctrl #(
    parameter int unsigned CAPACITY = plb_pkg::CAPACITY_DEF,
    parameter int unsigned CW       = $clog2(CAPACITY + 1),
    parameter int unsigned IW       = $clog2(CAPACITY)
) (
    input  logic [2:0]        req_type,
    input  logic [4:0]        position,
    input  logic [CW-1:0]     fill_count,
    output plb_pkg::plb_cmd_t cmd,
    output logic [IW-1:0]     target
);

    localparam int unsigned PW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          full;
    logic          empty;

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(fill_count);
    assign full    = (fill_count == CAP_CNT);
    assign empty   = (fill_count == '0);

    always_comb
    begin
        cmd.shift_up   = 1'b0;
        cmd.shift_down = 1'b0;
        cmd.status     = plb_pkg::ST_OK;
        target         = '0;
        case (req_type)
            plb_pkg::REQ_PUSH_BACK:
            begin
                target = IW'(fill_count);
                if (full)
                    cmd.status = plb_pkg::ST_FULL;
                else
                    cmd.shift_up = 1'b1;
            end
            plb_pkg::REQ_PUSH_FRONT:
            begin
                if (full)
                    cmd.status = plb_pkg::ST_FULL;
                else
                    cmd.shift_up = 1'b1;
            end
            plb_pkg::REQ_POP_BACK:
            begin
                target = IW'(fill_count - 1'b1);
                if (empty)
                    cmd.status = plb_pkg::ST_EMPTY;
                else
                    cmd.shift_down = 1'b1;
            end
            plb_pkg::REQ_POP_FRONT:
            begin
                if (empty)
                    cmd.status = plb_pkg::ST_EMPTY;
                else
                    cmd.shift_down = 1'b1;
            end
            plb_pkg::REQ_INSERT:
            begin
                target = IW'(position);
                // range check takes priority over full
                if (pos_ext > cnt_ext)
                    cmd.status = plb_pkg::ST_BADPOS;
                else if (full)
                    cmd.status = plb_pkg::ST_FULL;
                else
                    cmd.shift_up = 1'b1;
            end
            plb_pkg::REQ_ERASE:
            begin
                target = IW'(position);
                if (empty)
                    cmd.status = plb_pkg::ST_EMPTY;
                else if (pos_ext >= cnt_ext)
                    cmd.status = plb_pkg::ST_BADPOS;
                else
                    cmd.shift_down = 1'b1;
            end
            default:
            begin
                cmd.status = plb_pkg::ST_OK;
            end
        endcase
    end

endmodule

/* rtl/core/plb_cell.sv */
// One storage slot of the list; shifts to or from its neighbors on command.
module plb_cell #(
    parameter int unsigned DATA_WIDTH = plb_pkg::DATA_WIDTH_DEF,
    parameter int unsigned IW         = 4,
    parameter int unsigned INDEX      = 0
) (
    input  logic                  clk,
    input  plb_pkg::plb_cmd_t     cmd,
    input  logic [IW-1:0]         target,
    input  logic [DATA_WIDTH-1:0] ins_value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_up)
        begin
            if (MY_IDX > target)
                data_next = left_data;
            else if (MY_IDX == target)
                data_next = ins_value;
        end
        else if (cmd.shift_down && (MY_IDX >= target))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // slot under the target drives the removed value onto the OR bus
    assign tap  = (MY_IDX == target) ? data_reg : '0;

endmodule

/* tb/sv/tb_positional_list_buffer.sv */
// Self-checking testbench for positional_list_buffer: directed cases, then random traffic.
module tb_positional_list_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes six and seven have no name in the package; the block treats them as no-ops.
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    localparam int unsigned LIST_CAP    = plb_pkg::CAPACITY_DEF;
    localparam int          MAX_REPORTS = 10;
    localparam int          DRAIN_LIMIT = 20000;

    // One result transaction as the block should report it.
    typedef struct {
        logic [1:0]  status;
        logic [4:0]  count;
        logic [31:0] removed;
    } list_result_t;

    // DUT ports; every input has a known value from time zero.
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [2:0]  req_type      = plb_pkg::REQ_PUSH_BACK;
    logic [4:0]  position      = '0;
    logic [31:0] data_value    = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [1:0]  status;
    logic [4:0]  count;
    logic [31:0] removed_value;

    // Predictor state: the held elements, front of the list at index zero.
    logic [31:0]  held_values[$];
    // Results predicted for accepted requests, oldest first.
    list_result_t pending_results[$];

    int fail_count    = 0;
    int result_index  = 0;
    // Random traffic walks toward full while set, toward empty while clear.
    bit fill_trend    = 1'b1;

    // Receiver stall controls, changed per test.
    int rx_stall_pct   = 0;
    bit rx_long_stalls = 1'b0;
    int rx_hold_left   = 0;

    always #4 clk = ~clk;

    positional_list_buffer u_top (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .req_type,
        .position,
        .data_value,
        .out_valid,
        .out_ready,
        .status,
        .count,
        .removed_value
    );

    // Apply one request to the predictor and return the result it should produce.
    // Insert checks the position before fullness; erase checks emptiness before
    // the position.
    function automatic list_result_t apply_request(logic [2:0] req, logic [4:0] pos,
                                                   logic [31:0] value);
        list_result_t r;
        int unsigned  fill;
        fill      = held_values.size();
        r.status  = plb_pkg::ST_OK;
        r.removed = '0;
        case (req)
            plb_pkg::REQ_PUSH_BACK, plb_pkg::REQ_PUSH_FRONT:
            begin
                if (fill >= LIST_CAP)
                    r.status = plb_pkg::ST_FULL;
                else if (req == plb_pkg::REQ_PUSH_BACK)
                    held_values.push_back(value);
                else
                    held_values.push_front(value);
            end
            plb_pkg::REQ_POP_BACK:
            begin
                if (fill == 0)
                    r.status = plb_pkg::ST_EMPTY;
                else
                    r.removed = held_values.pop_back();
            end
            plb_pkg::REQ_POP_FRONT:
            begin
                if (fill == 0)
                    r.status = plb_pkg::ST_EMPTY;
                else
                    r.removed = held_values.pop_front();
            end
            plb_pkg::REQ_INSERT:
            begin
                if (pos > fill)
                    r.status = plb_pkg::ST_BADPOS;
                else if (fill >= LIST_CAP)
                    r.status = plb_pkg::ST_FULL;
                else
                    held_values.insert(pos, value);
            end
            plb_pkg::REQ_ERASE:
            begin
                if (fill == 0)
                    r.status = plb_pkg::ST_EMPTY;
                else if (pos >= fill)
                    r.status = plb_pkg::ST_BADPOS;
                else
                begin
                    r.removed = held_values[pos];
                    held_values.delete(pos);
                end
            end
            default:
            begin
                // reserved codes: nothing changes
            end
        endcase
        r.count = 5'(held_values.size());
        return r;
    endfunction

    // Present one request and hold it until the transaction completes. Valid is
    // left high so a following call keeps the channel busy without a bubble.
    task automatic send_req(logic [2:0] req, logic [4:0] pos, logic [31:0] value);
        in_valid   <= 1'b1;
        req_type   <= req;
        position   <= pos;
        data_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_request(req, pos, value));
    endtask

    // Pick one request. Most are well formed and drift toward full or empty so
    // the list sweeps its whole range; the rest is noise.
    task automatic send_random_request();
        int unsigned fill;
        int          roll;
        logic [2:0]  req;
        logic [4:0]  pos;
        fill = held_values.size();
        roll = $urandom_range(99);
        if (fill >= LIST_CAP)
            fill_trend = 1'b0;
        else if (fill == 0)
            fill_trend = 1'b1;
        else if ($urandom_range(49) == 0)
            fill_trend = ~fill_trend;
        pos = 5'($urandom_range(31));
        if (roll < 12)
        begin
            // noise: reserved codes, wild positions, any code at all
            case ($urandom_range(3))
                0:       req = $urandom_range(1) ? REQ_RSVD6 : REQ_RSVD7;
                1:       req = plb_pkg::REQ_INSERT;
                2:       req = plb_pkg::REQ_ERASE;
                default: req = 3'($urandom_range(7));
            endcase
        end
        else if ((roll < 82) == fill_trend)
        begin
            // growing step
            case ($urandom_range(2))
                0:       req = plb_pkg::REQ_PUSH_BACK;
                1:       req = plb_pkg::REQ_PUSH_FRONT;
                default: req = plb_pkg::REQ_INSERT;
            endcase
            pos = 5'($urandom_range(fill));
        end
        else
        begin
            // shrinking step
            case ($urandom_range(2))
                0:       req = plb_pkg::REQ_POP_BACK;
                1:       req = plb_pkg::REQ_POP_FRONT;
                default: req = plb_pkg::REQ_ERASE;
            endcase
            pos = (fill == 0) ? 5'd0 : 5'($urandom_range(fill - 1));
        end
        send_req(req, pos, $urandom());
    endtask

    // Random requests in bursts; a zero gap limit means a solid stream.
    task automatic send_random_items(int n_items, int tx_gap_max);
        int burst_left;
        int k;
        burst_left = $urandom_range(16, 1);
        for (k = 0; k < n_items; k++)
        begin
            send_random_request();
            if (tx_gap_max != 0)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(tx_gap_max, 1)) @(posedge clk);
                    burst_left = $urandom_range(16, 1);
                end
            end
        end
    endtask

    // Empty-list rejections, bad positions, every opcode, data extremes.
    task automatic test_directed_cases();
        rx_stall_pct   = 25;
        rx_long_stalls = 1'b0;
        send_req(plb_pkg::REQ_POP_BACK,   5'd0,  32'h0000_0000);
        send_req(plb_pkg::REQ_POP_FRONT,  5'd0,  32'hFFFF_FFFF);
        send_req(plb_pkg::REQ_ERASE,      5'd0,  32'h0000_0000);
        send_req(plb_pkg::REQ_ERASE,      5'd31, 32'h0000_0000);  // empty wins over bad position
        send_req(plb_pkg::REQ_INSERT,     5'd1,  32'h1111_1111);  // past the end of an empty list
        send_req(plb_pkg::REQ_INSERT,     5'd31, 32'hFFFF_FFFF);
        send_req(plb_pkg::REQ_INSERT,     5'd0,  32'hFFFF_FFFF);
        send_req(plb_pkg::REQ_PUSH_BACK,  5'd31, 32'h0000_0000);  // position ignored
        send_req(plb_pkg::REQ_PUSH_FRONT, 5'd0,  32'hA5A5_A5A5);
        send_req(plb_pkg::REQ_INSERT,     5'd3,  32'h5A5A_5A5A);  // insert at the end
        send_req(plb_pkg::REQ_INSERT,     5'd2,  32'h1234_5678);  // insert in the middle
        send_req(plb_pkg::REQ_ERASE,      5'd5,  32'h0000_0000);  // erase one past the end
        send_req(plb_pkg::REQ_ERASE,      5'd16, 32'h0000_0000);
        send_req(REQ_RSVD6,               5'd31, 32'hFFFF_FFFF);
        send_req(REQ_RSVD7,               5'd0,  32'h0000_0000);
        send_req(plb_pkg::REQ_ERASE,      5'd2,  32'h0000_0000);
        send_req(plb_pkg::REQ_ERASE,      5'd0,  32'h0000_0000);
        send_req(plb_pkg::REQ_POP_BACK,   5'd0,  32'h0000_0000);
        send_req(plb_pkg::REQ_POP_FRONT,  5'd0,  32'h0000_0000);
        send_req(plb_pkg::REQ_POP_BACK,   5'd0,  32'h0000_0000);  // takes the last element
        send_req(plb_pkg::REQ_POP_FRONT,  5'd0,  32'h0000_0000);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Fill to capacity, hit every full-list rejection, then drain by erase and pop.
    task automatic test_fill_and_drain();
        rx_stall_pct = 20;
        while (held_values.size() < LIST_CAP)
            send_req($urandom_range(1) ? plb_pkg::REQ_PUSH_BACK : plb_pkg::REQ_PUSH_FRONT,
                     '0, $urandom());
        send_req(plb_pkg::REQ_PUSH_BACK,  5'd0,  $urandom());
        send_req(plb_pkg::REQ_PUSH_FRONT, 5'd0,  $urandom());
        send_req(plb_pkg::REQ_INSERT,     5'd16, $urandom());    // in range, but full
        send_req(plb_pkg::REQ_INSERT,     5'd0,  $urandom());
        send_req(plb_pkg::REQ_INSERT,     5'd17, $urandom());    // bad position wins over full
        send_req(plb_pkg::REQ_ERASE,      5'd15, $urandom());    // last slot of a full list
        send_req(plb_pkg::REQ_INSERT,     5'd15, 32'hFFFF_FFFF); // refill at the top slot
        while (held_values.size() > 0)
        begin
            if ($urandom_range(1))
                send_req(plb_pkg::REQ_ERASE,
                         5'($urandom_range(held_values.size() - 1)), $urandom());
            else
                send_req($urandom_range(1) ? plb_pkg::REQ_POP_BACK : plb_pkg::REQ_POP_FRONT,
                         '0, $urandom());
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Solid stream with the receiver always ready: one transaction per cycle.
    task automatic test_back_to_back();
        rx_stall_pct   = 0;
        rx_long_stalls = 1'b0;
        send_random_items(450, 0);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Bursty sender against short random receiver stalls.
    task automatic test_bursty_traffic();
        rx_stall_pct   = 30;
        rx_long_stalls = 1'b0;
        send_random_items(450, 6);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Heavy backpressure: long receiver stalls fill the result register and
    // must hold off new requests without dropping one.
    task automatic test_receiver_backpressure();
        rx_stall_pct   = 50;
        rx_long_stalls = 1'b1;
        send_random_items(450, 2);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver ready pattern: random stalls, some stretched into long holds.
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            out_ready    <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
        begin
            out_ready    <= 1'b0;
            rx_hold_left <= rx_long_stalls ? $urandom_range(12) : 0;
        end
        else
            out_ready <= 1'b1;
    end

    // Result checker: every completed result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result %0d with nothing pending: status %0d count %0d removed %h",
                             result_index, status, count, removed_value);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || count !== want.count
                    || removed_value !== want.removed)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d mismatch: st %0d/%0d cnt %0d/%0d rm %h/%h (exp/got)",
                                 result_index, want.status, status, want.count, count,
                                 want.removed, removed_value);
                end
            end
            result_index++;
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int drain_cycles;
        drain_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_fill_and_drain();
        test_back_to_back();
        test_bursty_traffic();
        test_receiver_backpressure();

        // Let the receiver finish; anything still pending at the limit is lost.
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_results.size() != 0)
            $display("TB_ERROR");
        else
        begin
            // results are registered; this wait catches any stray result
            repeat (4) @(posedge clk);
            if (fail_count == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* positional_list_buffer.f */
rtl/core/plb_pkg.sv
rtl/core/plb_ctrl.sv
rtl/core/plb_cell.sv
rtl/core/positional_list_buffer.sv
tb/sv/tb_positional_list_buffer.sv
